### src/gnd_pkg.sv
package gnd_pkg;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  localparam logic [1:0] CFG_GRID_SCALE = 2'd0;
  localparam logic [1:0] CFG_INV_SCALE  = 2'd1;

  localparam logic [3:0]  GRID_SCALE_RST = 4'd2;
  localparam logic [16:0] INV_SCALE_RST  = 17'd32768;

  localparam logic [16:0] HALF_Q17 = 17'd65536;
  localparam logic signed [17:0] ONE_Q17 = 18'sd131072;
  localparam logic signed [17:0] OUT_MAX = 18'sd131071;
  localparam logic signed [17:0] OUT_MIN = -18'sd131072;

  typedef struct packed {
    logic               is_eval;
    logic               load_ok;
    logic signed [23:0] x_coord;
    logic signed [23:0] y_coord;
    logic [3:0]         grid_col;
    logic [3:0]         grid_row;
    logic signed [15:0] grad_x;
    logic signed [15:0] grad_y;
  } item_t;

endpackage

### src/gnd_ram.sv
module gnd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### src/gnd_front.sv
module gnd_front import gnd_pkg::*; #(
  parameter int MAX_SCALE = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_kind,
  input  logic signed [23:0] in_x_coord,
  input  logic signed [23:0] in_y_coord,
  input  logic [3:0]         in_grid_col,
  input  logic [3:0]         in_grid_row,
  input  logic signed [15:0] in_grad_x,
  input  logic signed [15:0] in_grad_y,
  output logic               pop_valid,
  output item_t              pop_item
);

  item_t       slot_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        push;
  item_t       new_item;

  assign busy      = (count_r == 2'd2);
  assign push      = start && !busy;
  assign pop_valid = (count_r != 2'd0);
  assign pop_item  = slot_r[rd_ptr_r];

  always_comb begin
    new_item.is_eval  = (in_kind == KIND_EVAL);
    // Loads aimed outside the grid are dropped here.
    new_item.load_ok  = (in_kind == KIND_LOAD) && (int'(in_grid_col) <= MAX_SCALE)
                        && (int'(in_grid_row) <= MAX_SCALE);
    new_item.x_coord  = in_x_coord;
    new_item.y_coord  = in_y_coord;
    new_item.grid_col = in_grid_col;
    new_item.grid_row = in_grid_row;
    new_item.grad_x   = in_grad_x;
    new_item.grad_y   = in_grad_y;
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop_valid ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop_valid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= new_item;
    end
  end

endmodule

### src/gnd_back.sv
module gnd_back import gnd_pkg::*; #(
  parameter int MAX_SCALE = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  input  item_t              pop_item,
  input  logic [3:0]         grid_scale,
  input  logic [16:0]        inv_scale,
  output logic               out_valid,
  output logic signed [17:0] out_noise_value
);

  localparam int HALF  = (MAX_SCALE + 2) / 2;
  localparam int BDEP  = HALF * HALF;
  localparam int AW    = (BDEP > 1) ? $clog2(BDEP) : 1;

  function automatic logic [AW-1:0] bank_addr(input logic [3:0] r, input logic [3:0] c);
    int a;
    a = int'(r[3:1]) * HALF + int'(c[3:1]);
    return a[AW-1:0];
  endfunction

  function automatic logic [16:0] map_u(input logic signed [23:0] c);
    logic [23:0] neg;
    logic [15:0] frac;
    neg  = -c;
    frac = c[23] ? neg[15:0] : c[15:0];
    return c[23] ? (HALF_Q17 - {1'b0, frac}) : (HALF_Q17 + {1'b0, frac});
  endfunction

  // Stage 0: clamp scale and split each coordinate into cell and weight.
  logic [3:0]  s_clamp;
  logic [20:0] px, py;

  always_comb begin
    if (grid_scale == 4'd0) begin
      s_clamp = 4'd1;
    end else if (int'(grid_scale) > MAX_SCALE) begin
      s_clamp = 4'(MAX_SCALE);
    end else begin
      s_clamp = grid_scale;
    end
    px = 21'(map_u(pop_item.x_coord)) * 21'(s_clamp);
    py = 21'(map_u(pop_item.y_coord)) * 21'(s_clamp);
  end

  logic        ev1_r, ld1_r;
  logic [3:0]  cx1_r, cy1_r, col1_r, row1_r;
  logic [16:0] wx1_r, wy1_r;
  logic [31:0] wdat1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev1_r <= 1'b0;
      ld1_r <= 1'b0;
    end else begin
      ev1_r <= pop_valid && pop_item.is_eval;
      ld1_r <= pop_valid && pop_item.load_ok;
    end
    cx1_r   <= px[20:17];
    cy1_r   <= py[20:17];
    wx1_r   <= px[16:0];
    wy1_r   <= py[16:0];
    col1_r  <= pop_item.grid_col;
    row1_r  <= pop_item.grid_row;
    wdat1_r <= {pop_item.grad_y, pop_item.grad_x};
  end

  // Stage 1: the four corners fall in four parity banks, one read each.
  logic [31:0]   rdata [4];
  logic [AW-1:0] raddr [4];
  logic [3:0]    bank_we;
  logic [AW-1:0] waddr;

  always_comb begin
    logic [3:0] rc, rr;
    waddr = bank_addr(row1_r, col1_r);
    for (int b = 0; b < 4; b++) begin
      rc = (cx1_r[0] == b[0]) ? cx1_r : cx1_r + 4'd1;
      rr = (cy1_r[0] == b[1]) ? cy1_r : cy1_r + 4'd1;
      raddr[b]   = bank_addr(rr, rc);
      bank_we[b] = ld1_r && (row1_r[0] == b[1]) && (col1_r[0] == b[0]);
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    gnd_ram #(.WIDTH(32), .DEPTH(BDEP)) u_ram (
      .clk   (clk),
      .we    (bank_we[g]),
      .waddr (waddr),
      .wdata (wdat1_r),
      .raddr (raddr[g]),
      .rdata (rdata[g])
    );
  end

  logic        ev2_r, cxp2_r, cyp2_r;
  logic [16:0] wx2_r, wy2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev2_r <= 1'b0;
    end else begin
      ev2_r <= ev1_r;
    end
    cxp2_r <= cx1_r[0];
    cyp2_r <= cy1_r[0];
    wx2_r  <= wx1_r;
    wy2_r  <= wy1_r;
  end

  // Stage 2: corner dot products; corner k has column step k[0], row step k[1].
  logic signed [34:0] dp [4];

  always_comb begin
    logic [1:0]         sel;
    logic signed [15:0] gx, gy;
    logic signed [17:0] dx, dy;
    logic signed [33:0] mx, my;
    for (int k = 0; k < 4; k++) begin
      sel = {cyp2_r ^ k[1], cxp2_r ^ k[0]};
      gx  = $signed(rdata[sel][15:0]);
      gy  = $signed(rdata[sel][31:16]);
      dx  = k[0] ? ($signed({1'b0, wx2_r}) - ONE_Q17) : $signed({1'b0, wx2_r});
      dy  = k[1] ? ($signed({1'b0, wy2_r}) - ONE_Q17) : $signed({1'b0, wy2_r});
      mx  = gx * dx;
      my  = gy * dy;
      dp[k] = 35'(mx) + 35'(my);
    end
  end

  logic               ev3_r;
  logic signed [34:0] dp3_r [4];
  logic [16:0]        wx3_r, wy3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev3_r <= 1'b0;
    end else begin
      ev3_r <= ev2_r;
    end
    dp3_r <= dp;
    wx3_r <= wx2_r;
    wy3_r <= wy2_r;
  end

  // Stage 3: lerp products along y.
  logic signed [35:0] dif_a, dif_b;
  logic signed [53:0] prd_a, prd_b;

  always_comb begin
    dif_a = 36'(dp3_r[2]) - 36'(dp3_r[0]);
    dif_b = 36'(dp3_r[3]) - 36'(dp3_r[1]);
    prd_a = dif_a * $signed({1'b0, wy3_r});
    prd_b = dif_b * $signed({1'b0, wy3_r});
  end

  logic               ev4_r;
  logic signed [53:0] prd_a4_r, prd_b4_r;
  logic signed [34:0] a4_r, b4_r;
  logic [16:0]        wx4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev4_r <= 1'b0;
    end else begin
      ev4_r <= ev3_r;
    end
    prd_a4_r <= prd_a;
    prd_b4_r <= prd_b;
    a4_r     <= dp3_r[0];
    b4_r     <= dp3_r[1];
    wx4_r    <= wx3_r;
  end

  // Stage 4: round to nearest, ties upward, and add the base.
  logic signed [53:0] rnd_a, rnd_b;
  logic signed [34:0] t1, t2;

  always_comb begin
    rnd_a = (prd_a4_r + 54'sd65536) >>> 17;
    rnd_b = (prd_b4_r + 54'sd65536) >>> 17;
    t1    = a4_r + $signed(rnd_a[34:0]);
    t2    = b4_r + $signed(rnd_b[34:0]);
  end

  logic               ev5_r;
  logic signed [34:0] t1_5_r, t2_5_r;
  logic [16:0]        wx5_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev5_r <= 1'b0;
    end else begin
      ev5_r <= ev4_r;
    end
    t1_5_r <= t1;
    t2_5_r <= t2;
    wx5_r  <= wx4_r;
  end

  // Stage 5: lerp product along x.
  logic signed [35:0] dif_x;
  logic signed [53:0] prd_x;

  always_comb begin
    dif_x = 36'(t2_5_r) - 36'(t1_5_r);
    prd_x = dif_x * $signed({1'b0, wx5_r});
  end

  logic               ev6_r;
  logic signed [53:0] prd_x6_r;
  logic signed [34:0] t1_6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev6_r <= 1'b0;
    end else begin
      ev6_r <= ev5_r;
    end
    prd_x6_r <= prd_x;
    t1_6_r   <= t1_5_r;
  end

  logic signed [53:0] rnd_x;
  logic signed [34:0] v;

  always_comb begin
    rnd_x = (prd_x6_r + 54'sd65536) >>> 17;
    v     = t1_6_r + $signed(rnd_x[34:0]);
  end

  logic               ev7_r;
  logic signed [34:0] v7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev7_r <= 1'b0;
    end else begin
      ev7_r <= ev6_r;
    end
    v7_r <= v;
  end

  // Stage 7: scale by the reciprocal grid size.
  logic signed [52:0] scl;

  assign scl = v7_r * $signed({1'b0, inv_scale});

  logic               ev8_r;
  logic signed [52:0] scl8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev8_r <= 1'b0;
    end else begin
      ev8_r <= ev7_r;
    end
    scl8_r <= scl;
  end

  // Stage 8: round to Q.16 and saturate.
  logic signed [52:0] res;
  logic signed [17:0] sat;

  always_comb begin
    res = (scl8_r + 53'sd1073741824) >>> 31;
    if (res > 53'(OUT_MAX)) begin
      sat = OUT_MAX;
    end else if (res < 53'(OUT_MIN)) begin
      sat = OUT_MIN;
    end else begin
      sat = res[17:0];
    end
  end

  logic               out_valid_r;
  logic signed [17:0] noise_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ev8_r;
    end
    noise_r <= sat;
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = noise_r;

endmodule

### src/gradient_noise_2d.sv
// Channel   Handshake                 Payload
// input     start / busy              in_kind, in_x_coord, in_y_coord, in_grid_col,
//                                     in_grid_row, in_grad_x, in_grad_y
// result    out_valid (one cycle)     out_noise_value
// config    cfg_we                    cfg_index, cfg_wdata
//
// One item is taken per cycle; an evaluate item gives its result after it passes through
// the two-entry queue, the banked grid read and the multiply chain.
// The four corners come from four grid banks split by row and column parity, one read each.
// Reset clears control state only; the grid holds no value until it is loaded.
// The receiver cannot stall, so the back end drains the queue every cycle.
module gradient_noise_2d import gnd_pkg::*; #(
  parameter int MAX_SCALE = 15
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_kind,
  input  logic signed [23:0] in_x_coord,
  input  logic signed [23:0] in_y_coord,
  input  logic [3:0]         in_grid_col,
  input  logic [3:0]         in_grid_row,
  input  logic signed [15:0] in_grad_x,
  input  logic signed [15:0] in_grad_y,
  output logic               out_valid,
  output logic signed [17:0] out_noise_value,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_wdata
);

  logic [3:0]  grid_scale_r, grid_scale_nxt;
  logic [16:0] inv_scale_r, inv_scale_nxt;
  logic        pop_valid;
  item_t       pop_item;

  always_comb begin
    grid_scale_nxt = grid_scale_r;
    inv_scale_nxt  = inv_scale_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_SCALE: grid_scale_nxt = cfg_wdata[3:0];
        CFG_INV_SCALE:  inv_scale_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_scale_r <= GRID_SCALE_RST;
      inv_scale_r  <= INV_SCALE_RST;
    end else begin
      grid_scale_r <= grid_scale_nxt;
      inv_scale_r  <= inv_scale_nxt;
    end
  end

  gnd_front #(.MAX_SCALE(MAX_SCALE)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_kind     (in_kind),
    .in_x_coord  (in_x_coord),
    .in_y_coord  (in_y_coord),
    .in_grid_col (in_grid_col),
    .in_grid_row (in_grid_row),
    .in_grad_x   (in_grad_x),
    .in_grad_y   (in_grad_y),
    .pop_valid   (pop_valid),
    .pop_item    (pop_item)
  );

  gnd_back #(.MAX_SCALE(MAX_SCALE)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .pop_valid       (pop_valid),
    .pop_item        (pop_item),
    .grid_scale      (grid_scale_r),
    .inv_scale       (inv_scale_r),
    .out_valid       (out_valid),
    .out_noise_value (out_noise_value)
  );

  // The back end drains one item per cycle, so the queue never fills.
  assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("input queue filled up");

  assert property (@(posedge clk) disable iff (!rst_n)
    !$past(cfg_we) |-> $stable(grid_scale_r) && $stable(inv_scale_r))
    else $error("configuration changed without a write");

  assert property (@(posedge clk) disable iff (!rst_n)
    pop_valid && !pop_item.is_eval |-> !pop_item.load_ok || int'(pop_item.grid_col) <= MAX_SCALE)
    else $error("load outside the grid was queued");

endmodule

### tb/gradient_noise_2d_checker.sv
module gradient_noise_2d_checker import gnd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic               in_kind,
  input  logic signed [23:0] in_x_coord,
  input  logic signed [23:0] in_y_coord,
  input  logic [3:0]         in_grid_col,
  input  logic [3:0]         in_grid_row,
  input  logic signed [15:0] in_grad_x,
  input  logic signed [15:0] in_grad_y,
  input  logic               out_valid,
  input  logic signed [17:0] out_noise_value,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_wdata,
  output int                 fail_count,
  output int                 noise_pending,
  output int                 noise_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_DIM = 16;
  localparam int SCALE_MAX = 15;

  logic signed [15:0] grad_x_mem [GRID_DIM*GRID_DIM];
  logic signed [15:0] grad_y_mem [GRID_DIM*GRID_DIM];
  logic [3:0]         scale_reg;
  logic [16:0]        inv_reg;
  logic signed [17:0] noise_queue [$];

  task automatic report(input string what);
    fail_count++;
    $display("[%0t] error: %s", $realtime, what);
  endtask

  function automatic void map_axis(input logic signed [23:0] c, input longint s,
                                   output longint cell_idx, output longint w);
    longint v, f, p;
    v = c;
    f = (v < 0 ? -v : v) & 64'hFFFF;
    if (v < 0) f = -f;
    p = (f + 65536) * s;
    cell_idx = p >>> 17;
    w = p & 64'h1FFFF;
  endfunction

  function automatic longint corner_dot(input longint col, input longint row,
                                        input longint dx, input longint dy);
    longint gx, gy;
    gx = grad_x_mem[row*GRID_DIM + col];
    gy = grad_y_mem[row*GRID_DIM + col];
    return gx*dx + gy*dy;
  endfunction

  // Rounds to nearest with ties upwards; >>> on a signed value floors.
  function automatic longint round_down_by(input longint v, input int n);
    return (v + (64'sd1 <<< (n-1))) >>> n;
  endfunction

  function automatic longint blend(input longint a, input longint b, input longint w);
    return a + round_down_by((b - a) * w, 17);
  endfunction

  function automatic logic signed [17:0] noise_at(input logic signed [23:0] x,
                                                  input logic signed [23:0] y);
    longint s, cx, cy, wx, wy, cx1, cy1, d1, d2, d3, d4, t1, t2, v, r;
    s = scale_reg;
    if (s == 0) s = 1;
    if (s > SCALE_MAX) s = SCALE_MAX;
    map_axis(x, s, cx, wx);
    map_axis(y, s, cy, wy);
    cx1 = (cx + 1 > s) ? s : cx + 1;
    cy1 = (cy + 1 > s) ? s : cy + 1;
    d1 = corner_dot(cx, cy, wx, wy);
    d2 = corner_dot(cx1, cy, wx - 131072, wy);
    d3 = corner_dot(cx, cy1, wx, wy - 131072);
    d4 = corner_dot(cx1, cy1, wx - 131072, wy - 131072);
    t1 = blend(d1, d3, wy);
    t2 = blend(d2, d4, wy);
    v = blend(t1, t2, wx);
    r = round_down_by(v * longint'(inv_reg), 31);
    if (r > OUT_MAX) r = OUT_MAX;
    if (r < OUT_MIN) r = OUT_MIN;
    return r[17:0];
  endfunction

  initial begin
    fail_count = 0;
    noise_seen = 0;
    scale_reg = GRID_SCALE_RST;
    inv_reg = INV_SCALE_RST;
  end

  assign noise_pending = noise_queue.size();

  always @(posedge clk) begin
    logic signed [17:0] want;
    if (!rst_n) begin
      scale_reg = GRID_SCALE_RST;
      inv_reg = INV_SCALE_RST;
      noise_queue.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_GRID_SCALE) scale_reg = cfg_wdata[3:0];
        else if (cfg_index == CFG_INV_SCALE) inv_reg = cfg_wdata;
      end
      if (start && !busy) begin
        if (in_kind == KIND_LOAD) begin
          grad_x_mem[in_grid_row*GRID_DIM + in_grid_col] = in_grad_x;
          grad_y_mem[in_grid_row*GRID_DIM + in_grid_col] = in_grad_y;
        end else begin
          noise_queue.push_back(noise_at(in_x_coord, in_y_coord));
        end
      end
      if (out_valid) begin
        noise_seen++;
        if (noise_queue.size() == 0) begin
          report($sformatf("unexpected noise result %0d", out_noise_value));
        end else begin
          want = noise_queue.pop_front();
          if (out_noise_value !== want)
            report($sformatf("noise_value got %0d, expected %0d", out_noise_value, want));
        end
      end
    end
  end

endmodule

### tb/gradient_noise_2d_tb.sv
module gradient_noise_2d_tb import gnd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_CYCLES = 12;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic               in_kind;
  logic signed [23:0] in_x_coord;
  logic signed [23:0] in_y_coord;
  logic [3:0]         in_grid_col;
  logic [3:0]         in_grid_row;
  logic signed [15:0] in_grad_x;
  logic signed [15:0] in_grad_y;
  logic               out_valid;
  logic signed [17:0] out_noise_value;
  logic               cfg_we;
  logic [1:0]         cfg_index;
  logic [16:0]        cfg_wdata;
  int                 fail_count;
  int                 noise_pending;
  int                 noise_seen;
  int                 cycle_count;
  int                 loads_sent;
  int                 evals_sent;
  int                 settings_used;
  int                 max_gap;

  gradient_noise_2d dut (.*);

  gradient_noise_2d_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycle_count);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Caller stands at a falling edge; returns at a falling edge with start still high, or low if a gap was drawn.
  // busy only moves at rising edges, so its value here is the one the next edge sees.
  task automatic send_item(input logic kind, input logic signed [23:0] x,
                           input logic signed [23:0] y, input logic [3:0] col,
                           input logic [3:0] row, input logic signed [15:0] gx,
                           input logic signed [15:0] gy);
    int gap;
    start = 1'b1;
    in_kind = kind;
    in_x_coord = x;
    in_y_coord = y;
    in_grid_col = col;
    in_grid_row = row;
    in_grad_x = gx;
    in_grad_y = gy;
    while (busy) @(negedge clk);
    @(negedge clk);
    if (kind == KIND_LOAD) loads_sent++;
    else evals_sent++;
    gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic send_eval(input logic signed [23:0] x, input logic signed [23:0] y);
    send_item(KIND_EVAL, x, y, 4'($urandom), 4'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic send_load(input logic [3:0] col, input logic [3:0] row);
    logic signed [15:0] gx, gy;
    case ($urandom_range(0, 7))
      0: begin gx = 16'sd16384; gy = -16'sd16384; end
      1: begin gx = -16'sd32768; gy = 16'sd32767; end
      2: begin gx = 16'($urandom); gy = 16'($urandom); end
      default: begin
        gx = 16'($urandom_range(0, 32768) - 16384);
        gy = 16'($urandom_range(0, 32768) - 16384);
      end
    endcase
    send_item(KIND_LOAD, 24'($urandom), 24'($urandom), col, row, gx, gy);
  endtask

  // Settings change only once every expected result is out and the pipe is empty.
  task automatic set_registers(input logic [3:0] scale, input logic [16:0] inv);
    start = 1'b0;
    while (noise_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = CFG_GRID_SCALE;
    cfg_wdata = {13'd0, scale};
    @(negedge clk);
    cfg_index = CFG_INV_SCALE;
    cfg_wdata = inv;
    @(negedge clk);
    cfg_index = CFG_UNUSED;
    cfg_wdata = 17'($urandom);
    @(negedge clk);
    cfg_we = 1'b0;
    settings_used++;
  endtask

  function automatic logic signed [23:0] random_coord();
    case ($urandom_range(0, 5))
      0: return 24'sh800000;
      1: return 24'sh7FFFFF;
      2: return {8'($urandom_range(0, 255)), 16'h0000};
      3: return {8'($urandom_range(0, 255)), 16'hFFFF};
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    logic [3:0] scale;
    logic [16:0] inv;
    start = 1'b0;
    in_kind = KIND_LOAD;
    in_x_coord = '0;
    in_y_coord = '0;
    in_grid_col = '0;
    in_grid_row = '0;
    in_grad_x = '0;
    in_grad_y = '0;
    cfg_we = 1'b0;
    cfg_index = CFG_GRID_SCALE;
    cfg_wdata = '0;
    loads_sent = 0;
    evals_sent = 0;
    settings_used = 0;
    max_gap = 0;
    rst_n = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;

    // Every grid point is loaded before anything is evaluated.
    for (int r = 0; r < 16; r++)
      for (int c = 0; c < 16; c++) begin
        max_gap = ($urandom_range(0, 3) == 0) ? 16 : 0;
        send_load(c[3:0], r[3:0]);
      end

    // Default settings: coordinate extremes, fraction edges and a reload of grid point (0,0).
    max_gap = 0;
    send_eval(24'sh800000, 24'sh7FFFFF);
    send_eval(24'sh7FFFFF, 24'sh800000);
    send_eval(24'sh000000, 24'sh000000);
    send_eval(24'sh00FFFF, -24'sh00FFFF);
    send_eval(-24'sh000001, 24'sh000001);
    send_eval(24'sh018000, -24'sh018000);
    send_item(KIND_LOAD, 24'sd0, 24'sd0, 4'd0, 4'd0, 16'sh7FFF, -16'sh8000);
    send_eval(24'sh000000, 24'sh000000);

    set_registers(4'd0, 17'd65536);
    send_eval(24'sh00FFFF, 24'sh00FFFF);
    send_eval(-24'sh00FFFF, 24'sh000000);
    set_registers(4'd15, 17'd131071);
    send_eval(24'sh7FFFFF, 24'sh7FFFFF);
    send_eval(-24'sh00FFFF, -24'sh00FFFF);
    send_eval(24'sh00FFFF, 24'sh000000);
    set_registers(4'd1, 17'd0);
    send_eval(24'sh123456, -24'sh123456);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin scale = 4'd15; inv = 17'd4369; end
        1: begin scale = 4'd1; inv = 17'd65536; end
        2: begin scale = 4'd0; inv = 17'd131071; end
        default: begin
          scale = 4'($urandom);
          inv = (scale == 0) ? 17'd65536 : 17'(65536 / scale);
        end
      endcase
      set_registers(scale, inv);
      for (int n = 0; n < 130; n++) begin
        if (n % 40 == 0) max_gap = ($urandom_range(0, 2) == 0) ? 0 : 16;
        if ($urandom_range(0, 4) == 0)
          send_load(4'($urandom), 4'($urandom));
        else
          send_eval(random_coord(), random_coord());
      end
    end

    start = 1'b0;
    while (noise_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("covered %0d loads and %0d evaluates under %0d register settings",
             loads_sent, evals_sent, settings_used + 1);
    $display("%0d noise results checked, %0d errors", noise_seen, fail_count);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
